// File: rtl/utf8_lenient_decoder_macros.svh
// Assertion macros for the lenient UTF-8 decoder.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef UTF8_LENIENT_DECODER_MACROS_SVH
`define UTF8_LENIENT_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UTF8LD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UTF8LD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/utf8ld_pkg.sv
// Shared types, constants and helper functions of the lenient UTF-8 decoder.
// No dependencies.
package utf8ld_pkg;

  // Default width of the wrapping byte offset.
  localparam int unsigned OFFSET_BITS_DEF = 16;
  // Payload bits carried by each continuation byte.
  localparam int unsigned CONT_SHIFT = 6;
  // Most results one input byte can cause.
  localparam int unsigned MAX_RES = 4;

  localparam int unsigned CP_W    = 21;
  localparam int unsigned START_W = 16;
  localparam int unsigned LEN_W   = 3;
  localparam int unsigned CNT_W   = 3;

  // One decoded result.
  typedef struct packed {
    logic [CP_W-1:0]    code_point;
    logic [START_W-1:0] byte_start;
    logic [LEN_W-1:0]   byte_length;
    logic               last_of_run;
  } res_t;

  // All results caused by one input byte, in output order.
  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [CNT_W-1:0]   n;
  } burst_t;

  // Sequence length announced by a lead byte; bad prefixes count as one.
  function automatic logic [LEN_W-1:0] lead_len(input logic [7:0] b);
    logic [LEN_W-1:0] len;
    len = 3'd1;
    if (b[7:5] == 3'b110) len = 3'd2;
    else if (b[7:4] == 4'b1110) len = 3'd3;
    else if (b[7:3] == 5'b11110) len = 3'd4;
    return len;
  endfunction

endpackage

// File: rtl/utf8ld_if.sv
// Valid/ready stream interfaces for the input bytes and the decoded results.
// Depends on utf8ld_pkg for the field widths.
interface utf8ld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface utf8ld_out_if;
  logic                               valid;
  logic                               ready;
  logic [utf8ld_pkg::CP_W-1:0]        code_point;
  logic [utf8ld_pkg::START_W-1:0]     byte_start;
  logic [utf8ld_pkg::LEN_W-1:0]       byte_length;
  logic                               last_of_run;

  modport source (output valid, output code_point, output byte_start, output byte_length,
                  output last_of_run, input ready);
  modport sink (input valid, input code_point, input byte_start, input byte_length,
                input last_of_run, output ready);
endinterface

// File: rtl/utf8ld_decode.sv
// Sequence state and single-pass decode of one byte into up to four results.
// Depends on utf8ld_pkg.
module utf8ld_decode #(
  parameter int unsigned OFFSET_BITS = utf8ld_pkg::OFFSET_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  logic [7:0]         text_byte_i,
  input  logic               end_of_text_i,
  output utf8ld_pkg::burst_t burst_o
);

  localparam int unsigned CS = utf8ld_pkg::CONT_SHIFT;

  logic [7:0]             pend_q [3];
  logic [1:0]             pcnt_q, pcnt_d;
  logic [2:0]             exp_q, exp_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;
  logic [OFFSET_BITS-1:0] seq_q, seq_d;

  logic                   open, is_cont, complete, ok, good, flush, tail;
  logic                   hold_new, append;
  logic [2:0]             len_b;
  logic [1:0]             nflush;
  logic [utf8ld_pkg::CP_W-1:0] cp;

  // Classify the byte against the open sequence.
  always_comb begin
    open     = (pcnt_q != 2'd0) && (exp_q >= 3'd2) && (exp_q <= 3'd4);
    is_cont  = (text_byte_i[7:6] == 2'b10);
    len_b    = utf8ld_pkg::lead_len(text_byte_i);
    complete = open && is_cont && (({1'b0, pcnt_q} + 3'd1) == exp_q);

    case (exp_q)
      3'd2: begin
        cp = {10'd0, pend_q[0][4:0], text_byte_i[CS-1:0]};
        ok = (cp >= 21'h80);
      end
      3'd3: begin
        cp = {5'd0, pend_q[0][3:0], pend_q[1][CS-1:0], text_byte_i[CS-1:0]};
        ok = (cp >= 21'h800) && ((cp < 21'hD800) || (cp > 21'hDFFF));
      end
      default: begin
        cp = {pend_q[0][2:0], pend_q[1][CS-1:0], pend_q[2][CS-1:0], text_byte_i[CS-1:0]};
        ok = (cp >= 21'h10000) && (cp <= 21'h10FFFF);
      end
    endcase

    good     = complete && ok;
    append   = open && is_cont && !complete && !end_of_text_i;
    flush    = open && (!is_cont || (complete && !ok) || (is_cont && !complete && end_of_text_i));
    hold_new = (!open || !is_cont) && (len_b != 3'd1) && !end_of_text_i;
    if (!open || !is_cont) tail = (len_b == 3'd1) || end_of_text_i;
    else if (complete) tail = !ok;
    else tail = end_of_text_i;
    nflush   = flush ? pcnt_q : 2'd0;
  end

  // Build the result list: a decoded code point, or held bytes, then the new byte.
  always_comb begin
    if (good) burst_o.n = 3'd1;
    else burst_o.n = {1'b0, nflush} + {2'd0, tail};
    for (int i = 0; i < int'(utf8ld_pkg::MAX_RES); i++) begin
      if (good && i == 0) begin
        burst_o.res[i].code_point  = cp;
        burst_o.res[i].byte_start  = 16'(seq_q);
        burst_o.res[i].byte_length = exp_q;
      end else if (i < 3 && 2'(i) < nflush) begin
        burst_o.res[i].code_point  = {13'd0, pend_q[(i < 3) ? 2'(i) : 2'd0]};
        burst_o.res[i].byte_start  = 16'(seq_q + OFFSET_BITS'(i));
        burst_o.res[i].byte_length = 3'd1;
      end else begin
        burst_o.res[i].code_point  = {13'd0, text_byte_i};
        burst_o.res[i].byte_start  = 16'(off_q);
        burst_o.res[i].byte_length = 3'd1;
      end
      burst_o.res[i].last_of_run = ((3'(i) + 3'd1) == burst_o.n);
    end
  end

  // Next sequence state.
  always_comb begin
    pcnt_d = pcnt_q;
    exp_d  = exp_q;
    off_d  = off_q;
    seq_d  = seq_q;
    if (end_of_text_i) begin
      pcnt_d = 2'd0;
      exp_d  = 3'd0;
      off_d  = '0;
    end else begin
      off_d = off_q + OFFSET_BITS'(1);
      if (hold_new) begin
        pcnt_d = 2'd1;
        exp_d  = len_b;
        seq_d  = off_q;
      end else if (append) begin
        pcnt_d = pcnt_q + 2'd1;
      end else begin
        pcnt_d = 2'd0;
        exp_d  = 3'd0;
      end
    end
  end

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q <= 2'd0;
      exp_q  <= 3'd0;
      off_q  <= '0;
      seq_q  <= '0;
    end else if (take_i) begin
      pcnt_q <= pcnt_d;
      exp_q  <= exp_d;
      off_q  <= off_d;
      seq_q  <= seq_d;
    end
  end

  // Held bytes of the open sequence.
  always_ff @(posedge clk_i) begin
    if (take_i && !end_of_text_i) begin
      if (hold_new) pend_q[0] <= text_byte_i;
      else if (append) pend_q[pcnt_q] <= text_byte_i;
    end
  end

endmodule

// File: rtl/utf8_lenient_decoder.sv
// Top level of the lenient UTF-8 decoder: decode stage plus result burst buffer.
// Depends on utf8ld_pkg, utf8ld_if, utf8ld_decode and the assertion macro header.
//
//   channel  | dir | payload                                             | handshake
//   in_i     | in  | text_byte, end_of_text                              | valid/ready
//   out_o    | out | code_point, byte_start, byte_length, last_of_run    | valid/ready
//
// A byte is decoded in the cycle it is accepted; its results appear in the cycle after.
// One byte per cycle is sustained while each byte yields at most one result and the
// output does not stall. A byte yielding several results holds the burst buffer until
// all have left, one per output transaction, and the next byte waits for the last one.
// Reset clears the control state and the buffer; a stalled output holds its result.
`include "utf8_lenient_decoder_macros.svh"

module utf8_lenient_decoder #(
  parameter int unsigned OFFSET_BITS = utf8ld_pkg::OFFSET_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  utf8ld_in_if.sink    in_i,
  utf8ld_out_if.source out_o
);

  localparam int unsigned NR = utf8ld_pkg::MAX_RES;

  utf8ld_pkg::burst_t          burst;
  utf8ld_pkg::res_t            buf_q [NR];
  logic [utf8ld_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                        take, pop;

  // Accept when the buffer is empty or its last entry leaves this cycle.
  assign in_i.ready = (cnt_q == '0) || ((cnt_q == 3'd1) && out_o.ready);
  assign take       = in_i.valid && in_i.ready;
  assign pop        = out_o.valid && out_o.ready;

  utf8ld_decode #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .text_byte_i  (in_i.text_byte),
    .end_of_text_i(in_i.end_of_text),
    .burst_o      (burst)
  );

  // Buffer fill count.
  always_comb begin
    if (take) cnt_d = burst.n;
    else if (pop) cnt_d = cnt_q - 3'd1;
    else cnt_d = cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Burst buffer: load a whole burst, shift toward the head on each output transaction.
  always_ff @(posedge clk_i) begin
    if (take) begin
      for (int i = 0; i < int'(NR); i++) buf_q[i] <= burst.res[i];
    end else if (pop) begin
      for (int i = 0; i < int'(NR) - 1; i++) buf_q[i] <= buf_q[i+1];
    end
  end

  // Output side.
  assign out_o.valid       = (cnt_q != '0);
  assign out_o.code_point  = buf_q[0].code_point;
  assign out_o.byte_start  = buf_q[0].byte_start;
  assign out_o.byte_length = buf_q[0].byte_length;
  assign out_o.last_of_run = buf_q[0].last_of_run;

  // Checks on the buffer and the decode results.
  `UTF8LD_ASSERT_NOW(a_last_entry_ends_run, out_o.valid && (cnt_q == 3'd1),
                     out_o.last_of_run, "final buffered result lacks last_of_run")
  `UTF8LD_ASSERT_NOW(a_no_take_when_busy, take, cnt_q <= 3'd1,
                     "byte accepted while results still queued")
  `UTF8LD_ASSERT_NOW(a_len_range, out_o.valid,
                     (out_o.byte_length != 3'd0) && (out_o.byte_length <= 3'd4),
                     "byte_length out of range")
  `UTF8LD_ASSERT_NEXT(a_stall_holds, out_o.valid && !out_o.ready && !take,
                      out_o.valid && $stable(out_o.code_point), "stalled result changed")

endmodule

// File: tb/tb_utf8_lenient_decoder.sv
// Self-checking testbench for the lenient UTF-8 decoder: random and directed byte texts.
// Depends on utf8ld_pkg, the utf8ld_in_if / utf8ld_out_if interfaces and utf8_lenient_decoder.
// A built-in predictor computes the expected code points and checks every output transaction.
module tb_utf8_lenient_decoder;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned RANDOM_BYTES = 355;

  // Directed bytes as {end_of_text, byte}.
  localparam logic [8:0] DIRECTED [25] = '{
    9'h000, 9'h07F,                   // ASCII extremes
    9'h0C2, 9'h080,                   // smallest two-byte code point
    9'h0C0, 9'h080,                   // overlong two-byte form
    9'h0ED, 9'h0A0, 9'h080,           // surrogate
    9'h0F4, 9'h090, 9'h080, 9'h080,   // just above the Unicode range
    9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,   // largest code point
    9'h0FF, 9'h080,                   // bad prefix, then a stray continuation
    9'h0E2, 9'h082, 9'h041,           // sequence cut by an ASCII byte
    9'h0E2, 9'h182,                   // sequence cut by the end of the text
    9'h1C3                            // multi-byte lead as the final byte
  };

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } byte_item_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  utf8ld_in_if  in_if ();
  utf8ld_out_if out_if ();

  utf8_lenient_decoder u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Clock with a period of 10.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  byte_item_t        text_q [$];
  logic [7:0]        draft_q [$];
  utf8ld_pkg::res_t  cp_expect_q [$];
  utf8ld_pkg::res_t  burst_q [$];
  byte_item_t        next_item;
  utf8ld_pkg::res_t  oldest_cp;

  int unsigned cycles = 0;
  int unsigned err_cnt = 0;
  int unsigned bytes_in = 0;
  int unsigned texts_in = 0;
  int unsigned results_seen = 0;
  int unsigned rand_bytes = 0;
  logic        calm;

  // Decoder shadow state: the open sequence and the running offset.
  logic [7:0]  held_bytes [3];
  int unsigned held_cnt = 0;
  int unsigned want_len = 0;
  logic [15:0] next_offset = '0;
  logic [15:0] lead_offset = '0;

  // A recurring stretch in which neither side idles.
  assign calm = (cycles % 5000) >= 4200;

  task automatic report_err(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycles, msg);
    err_cnt++;
  endtask

  task automatic add_result(input logic [20:0] cp, input logic [15:0] start,
                            input int unsigned len);
    utf8ld_pkg::res_t r;
    r.code_point  = cp;
    r.byte_start  = start;
    r.byte_length = len[2:0];
    r.last_of_run = 1'b0;
    burst_q = {burst_q, r};
  endtask

  // Every held byte comes out alone, lead first, and the sequence closes.
  task automatic release_held();
    for (int unsigned i = 0; i < held_cnt; i++)
      add_result({13'd0, held_bytes[i]}, lead_offset + 16'(i), 1);
    held_cnt = 0;
    want_len = 0;
  endtask

  // A byte seen outside a sequence: single-byte result or a new lead.
  task automatic open_or_emit(input logic [7:0] b, input logic [15:0] off, input logic eot);
    int unsigned len;
    len = 1;
    if (b >= 8'hC0 && b <= 8'hDF) len = 2;
    else if (b >= 8'hE0 && b <= 8'hEF) len = 3;
    else if (b >= 8'hF0 && b <= 8'hF7) len = 4;
    if (len == 1 || eot) begin
      add_result({13'd0, b}, off, 1);
    end else begin
      held_bytes[0] = b;
      held_cnt = 1;
      want_len = len;
      lead_offset = off;
    end
  endtask

  // Works out the results of one accepted byte and queues them as expected.
  task automatic decode_byte(input logic [7:0] b, input logic eot);
    logic [20:0] cp;
    logic        ok;
    logic [15:0] off;
    burst_q.delete();
    off = next_offset;
    if (held_cnt == 0) begin
      open_or_emit(b, off, eot);
    end else if (b[7:6] != 2'b10) begin
      release_held();
      open_or_emit(b, off, eot);
    end else if (held_cnt + 1 == want_len) begin
      cp = 21'(held_bytes[0] & (8'h7F >> want_len));
      for (int unsigned i = 1; i < held_cnt; i++)
        cp = (cp << utf8ld_pkg::CONT_SHIFT) | 21'(held_bytes[i][5:0]);
      cp = (cp << utf8ld_pkg::CONT_SHIFT) | 21'(b[5:0]);
      case (want_len)
        2: ok = cp >= 21'h80;
        3: ok = cp >= 21'h800 && (cp < 21'hD800 || cp > 21'hDFFF);
        default: ok = cp >= 21'h10000 && cp <= 21'h10FFFF;
      endcase
      if (ok) begin
        add_result(cp, lead_offset, want_len);
        held_cnt = 0;
        want_len = 0;
      end else begin
        release_held();
        add_result({13'd0, b}, off, 1);
      end
    end else if (eot) begin
      release_held();
      add_result({13'd0, b}, off, 1);
    end else begin
      held_bytes[held_cnt] = b;
      held_cnt++;
    end
    if (eot) begin
      held_cnt = 0;
      want_len = 0;
      next_offset = '0;
    end else begin
      next_offset = next_offset + 16'd1;
    end
    if (burst_q.size() > 0) burst_q[burst_q.size()-1].last_of_run = 1'b1;
    cp_expect_q = {cp_expect_q, burst_q};
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic eot);
    byte_item_t it;
    it.text_byte = b;
    it.end_of_text = eot;
    text_q = {text_q, it};
  endtask

  // Appends one byte to the text being drafted.
  task automatic add_draft(input logic [7:0] b);
    draft_q = {draft_q, b};
  endtask

  // Standard UTF-8 bit layout for a given length, whatever the value.
  task automatic encode_cp(input logic [20:0] cp, input int unsigned len);
    case (len)
      1: add_draft(cp[7:0]);
      2: begin
        add_draft({3'b110, cp[10:6]});
        add_draft({2'b10, cp[5:0]});
      end
      3: begin
        add_draft({4'b1110, cp[15:12]});
        add_draft({2'b10, cp[11:6]});
        add_draft({2'b10, cp[5:0]});
      end
      default: begin
        add_draft({5'b11110, cp[20:18]});
        add_draft({2'b10, cp[17:12]});
        add_draft({2'b10, cp[11:6]});
        add_draft({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // Hands the drafted text to the driver, flagging its last byte.
  task automatic flush_draft();
    foreach (draft_q[i]) queue_byte(draft_q[i], i == draft_q.size() - 1);
    draft_q.delete();
  endtask

  // One random text: mostly well-formed code points, some broken forms and noise.
  task automatic add_random_text();
    int unsigned n;
    int unsigned kind;
    int unsigned len;
    logic [20:0] cp;
    n = $urandom_range(1, 10);
    for (int unsigned e = 0; e < n; e++) begin
      kind = $urandom_range(0, 99);
      len = $urandom_range(2, 4);
      if (kind < 65) begin
        len = $urandom_range(1, 4);
        case (len)
          1: cp = 21'($urandom_range(0, 'h7F));
          2: cp = 21'($urandom_range('h80, 'h7FF));
          3: begin
            cp = 21'($urandom_range('h800, 'hFFFF));
            if (cp >= 'hD800 && cp <= 'hDFFF) cp = cp ^ 21'h1000;
          end
          default: cp = 21'($urandom_range('h10000, 'h10FFFF));
        endcase
        encode_cp(cp, len);
      end else if (kind < 72) begin
        // Overlong form.
        if (len == 2) cp = 21'($urandom_range(0, 'h7F));
        else if (len == 3) cp = 21'($urandom_range(0, 'h7FF));
        else cp = 21'($urandom_range(0, 'hFFFF));
        encode_cp(cp, len);
      end else if (kind < 77) begin
        encode_cp(21'($urandom_range('hD800, 'hDFFF)), 3);
      end else if (kind < 82) begin
        encode_cp(21'($urandom_range('h110000, 'h1FFFFF)), 4);
      end else if (kind < 88) begin
        // Truncated sequence.
        encode_cp(21'($urandom_range(0, 'h1FFFFF)), len);
        repeat ($urandom_range(1, len - 1)) void'(draft_q.pop_back());
      end else if (kind < 94) begin
        add_draft(8'($urandom_range(0, 255)));
      end else begin
        add_draft(8'($urandom_range('h80, 'hBF)));
      end
    end
    rand_bytes += draft_q.size();
    flush_draft();
  endtask

  // Holds the sender back until every expected result has arrived.
  task automatic wait_drained();
    @(posedge clk_i);
    while (text_q.size() != 0 || in_if.valid || cp_expect_q.size() != 0)
      @(posedge clk_i);
  endtask

  // Driver: predicts each accepted transaction and presents the next byte.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid       <= 1'b0;
      in_if.text_byte   <= '0;
      in_if.end_of_text <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        decode_byte(in_if.text_byte, in_if.end_of_text);
        bytes_in++;
        if (in_if.end_of_text) texts_in++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (text_q.size() > 0 && (calm || $urandom_range(0, 99) >= 33)) begin
          next_item = text_q.pop_front();
          in_if.valid       <= 1'b1;
          in_if.text_byte   <= next_item.text_byte;
          in_if.end_of_text <= next_item.end_of_text;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares each output transaction with the oldest expected one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (cp_expect_q.size() == 0) begin
          report_err($sformatf("unexpected result cp=%h start=%0d len=%0d",
                               out_if.code_point, out_if.byte_start, out_if.byte_length));
        end else begin
          oldest_cp = cp_expect_q.pop_front();
          if (out_if.code_point !== oldest_cp.code_point)
            report_err($sformatf("code_point %h, expected %h",
                                 out_if.code_point, oldest_cp.code_point));
          if (out_if.byte_start !== oldest_cp.byte_start)
            report_err($sformatf("byte_start %0d, expected %0d",
                                 out_if.byte_start, oldest_cp.byte_start));
          if (out_if.byte_length !== oldest_cp.byte_length)
            report_err($sformatf("byte_length %0d, expected %0d",
                                 out_if.byte_length, oldest_cp.byte_length));
          if (out_if.last_of_run !== oldest_cp.last_of_run)
            report_err($sformatf("last_of_run %b, expected %b",
                                 out_if.last_of_run, oldest_cp.last_of_run));
        end
      end
      out_if.ready <= calm || ($urandom_range(0, 99) >= 33);
    end
  end

  // Cycle counter and timeout.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycles, cp_expect_q.size());
      $display("tb_utf8_lenient_decoder failed");
      $finish;
    end
  end

  // Stimulus sequence and end of run.
  initial begin
    in_if.valid       = 1'b0;
    in_if.text_byte   = '0;
    in_if.end_of_text = 1'b0;
    out_if.ready      = 1'b0;
    rst_ni            = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED[i]) queue_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
    wait_drained();

    while (rand_bytes < RANDOM_BYTES / 2) add_random_text();
    wait_drained();
    while (rand_bytes < RANDOM_BYTES) add_random_text();
    wait_drained();

    repeat (20) @(posedge clk_i);
    $display("Sent %0d bytes in %0d texts and checked %0d results: every lead length,",
             bytes_in, texts_in, results_seen);
    $display("overlong, surrogate, out-of-range, truncated and stray bytes.");
    if (err_cnt == 0) begin
      $display("tb_utf8_lenient_decoder passed");
    end else begin
      $display("%0d mismatches.", err_cnt);
      $display("tb_utf8_lenient_decoder failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/utf8ld_pkg.sv
rtl/utf8ld_if.sv
rtl/utf8ld_decode.sv
rtl/utf8_lenient_decoder.sv
tb/tb_utf8_lenient_decoder.sv
